// File: hdl/spectral_tone_burst_detector_macros.svh
// Assertion macros used by the checker of the spectral tone burst detector.
`ifndef SPECTRAL_TONE_BURST_DETECTOR_MACROS_SVH
`define SPECTRAL_TONE_BURST_DETECTOR_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define STBD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define STBD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/stbd_pkg.sv
// Types and constants shared by the spectral tone burst detector modules.
`timescale 1ns / 1ps
package stbd_pkg;

   localparam int BIN_W       = 10;
   localparam int THR_W       = 8;
   localparam int K_W         = 2 * THR_W;
   localparam int HITS_W      = 8;
   localparam int MAG_PORT_W  = 16;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_BAND_FIRST = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_LAST  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_Q4       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HIT_FRAMES = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MISS_LIMIT = 3'd4;

   localparam logic [BIN_W-1:0]  RESET_BAND_FIRST = 10'd85;
   localparam logic [BIN_W-1:0]  RESET_BAND_LAST  = 10'd149;
   localparam logic [THR_W-1:0]  RESET_Z_Q4       = 8'd80;
   localparam logic [HITS_W-1:0] RESET_HIT_FRAMES = 8'd16;
   localparam logic [HITS_W-1:0] RESET_MISS_LIMIT = 8'd4;

   localparam logic [HITS_W-1:0] HITS_MAX = 8'hFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_LVL_W = 3;

   typedef struct packed {
      logic [BIN_W-1:0]  band_first_bin;
      logic [BIN_W-1:0]  band_last_bin;
      logic [THR_W-1:0]  z_q4;
      logic [HITS_W-1:0] hit_frames;
      logic [HITS_W-1:0] miss_limit;
   } cfg_type;

   typedef struct packed {
      logic              band_hit;
      logic              detected;
      logic [HITS_W-1:0] hits_so_far;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIFF,
      BK_SQ,
      BK_DONE
   } back_state_type;

endpackage

// File: hdl/stbd_queue.sv
// Short queue of finished frame statistics between the front and back parts.
`timescale 1ns / 1ps
module stbd_queue #(
   parameter int WIDTH = 96
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [WIDTH-1:0]                   push_data,
   input  logic                               pop,
   output logic [WIDTH-1:0]                   pop_data,
   output logic [stbd_pkg::QUEUE_LVL_W-1:0]   level,
   output logic                               empty
);
   import stbd_pkg::*;

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LVL_W-1:0] level_ff, level_in;

   always_comb begin
      case ({push, pop})
         2'b10:   level_in = level_ff + QUEUE_LVL_W'(1);
         2'b01:   level_in = level_ff - QUEUE_LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign level    = level_ff;
   assign empty    = (level_ff == '0);

endmodule

// File: hdl/stbd_front.sv
// Front part: takes bins, accumulates count, sum, sum of squares and band maximum.
`timescale 1ns / 1ps
module stbd_front #(
   parameter int MAX_BINS = 1024,
   parameter int CNT_W    = 11,
   parameter int MAG_W    = 16,
   parameter int S1_W     = 27,
   parameter int S2_W     = 43
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stbd_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [MAG_W-1:0]                  req_magnitude,
   input  logic                              req_frame_end,
   input  logic [stbd_pkg::QUEUE_LVL_W-1:0]  queue_level,
   output logic                              push,
   output logic [CNT_W-1:0]                  push_n,
   output logic [S1_W-1:0]                   push_sum,
   output logic [S2_W-1:0]                   push_sq,
   output logic [MAG_W-1:0]                  push_max
);
   import stbd_pkg::*;

   localparam int CMP_W = (CNT_W > BIN_W) ? CNT_W : BIN_W;
   localparam int SQ_W  = 2 * MAG_W;

   logic                   accept;
   logic                   counted, in_band;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CMP_W-1:0]       idx_ext;
   logic [QUEUE_LVL_W-1:0] pending;

   logic                   pipe_vld_ff, pipe_last_ff, pipe_cnt_ff, pipe_band_ff;
   logic [MAG_W-1:0]       pipe_mag_ff;
   logic [SQ_W-1:0]        pipe_sq_ff;

   logic [CNT_W-1:0]       acc_n_ff, acc_n_in;
   logic [S1_W-1:0]        acc_sum_ff, acc_sum_in;
   logic [S2_W-1:0]        acc_sq_ff, acc_sq_in;
   logic [MAG_W-1:0]       acc_max_ff, acc_max_in;

   assign pending   = queue_level + QUEUE_LVL_W'(pipe_vld_ff && pipe_last_ff);
   assign req_stall = (pending >= QUEUE_LVL_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign idx_ext = CMP_W'(idx_ff);
   assign counted = (idx_ff < CNT_W'(MAX_BINS));
   assign in_band = counted && (idx_ext >= CMP_W'(cfg.band_first_bin)) &&
                    (idx_ext <= CMP_W'(cfg.band_last_bin));

   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         if (req_frame_end) begin
            idx_in = '0;
         end else if (counted) begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         pipe_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pipe_last_ff <= req_frame_end;
         pipe_cnt_ff  <= counted;
         pipe_band_ff <= in_band;
         pipe_mag_ff  <= req_magnitude;
         pipe_sq_ff   <= SQ_W'(req_magnitude) * SQ_W'(req_magnitude);
      end
   end

   always_comb begin
      acc_n_in   = acc_n_ff;
      acc_sum_in = acc_sum_ff;
      acc_sq_in  = acc_sq_ff;
      acc_max_in = acc_max_ff;
      if (pipe_cnt_ff) begin
         acc_n_in   = acc_n_ff + CNT_W'(1);
         acc_sum_in = acc_sum_ff + S1_W'(pipe_mag_ff);
         acc_sq_in  = acc_sq_ff + S2_W'(pipe_sq_ff);
         if (pipe_band_ff && (pipe_mag_ff > acc_max_ff)) begin
            acc_max_in = pipe_mag_ff;
         end
      end
   end

   assign push     = pipe_vld_ff && pipe_last_ff;
   assign push_n   = acc_n_in;
   assign push_sum = acc_sum_in;
   assign push_sq  = acc_sq_in;
   assign push_max = acc_max_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_n_ff   <= '0;
         acc_sum_ff <= '0;
         acc_sq_ff  <= '0;
         acc_max_ff <= '0;
      end else if (pipe_vld_ff) begin
         if (pipe_last_ff) begin
            acc_n_ff   <= '0;
            acc_sum_ff <= '0;
            acc_sq_ff  <= '0;
            acc_max_ff <= '0;
         end else begin
            acc_n_ff   <= acc_n_in;
            acc_sum_ff <= acc_sum_in;
            acc_sq_ff  <= acc_sq_in;
            acc_max_ff <= acc_max_in;
         end
      end
   end

endmodule

// File: hdl/stbd_back.sv
// Back part: evaluates the z-score test per frame and runs the hit/miss counters.
`timescale 1ns / 1ps
module stbd_back #(
   parameter int CNT_W = 11,
   parameter int MAG_W = 16,
   parameter int S1_W  = 27,
   parameter int S2_W  = 43
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stbd_pkg::cfg_type      cfg,
   input  logic                   queue_empty,
   output logic                   pop,
   input  logic [CNT_W-1:0]       pop_n,
   input  logic [S1_W-1:0]        pop_sum,
   input  logic [S2_W-1:0]        pop_sq,
   input  logic [MAG_W-1:0]       pop_max,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stbd_pkg::result_type   rsp
);
   import stbd_pkg::*;

   localparam int NM_W  = CNT_W + MAG_W;
   localparam int DD_W  = 2 * NM_W;
   localparam int LHS_W = DD_W + 8;
   localparam int A_W   = CNT_W + S2_W;
   localparam int B_W   = 2 * S1_W;
   localparam int VAR_W = (A_W > B_W) ? A_W : B_W;
   localparam int RHS_W = VAR_W + K_W;
   localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   back_state_type     state_ff, state_in;
   logic               out_load;

   logic [CNT_W-1:0]   n_ff;
   logic [S1_W-1:0]    s1_ff;
   logic [S2_W-1:0]    s2_ff;
   logic [MAG_W-1:0]   m_ff;
   logic [K_W-1:0]     k_ff;
   logic [NM_W-1:0]    nm_ff, d_ff;
   logic [A_W-1:0]     a_ff;
   logic [B_W-1:0]     b_ff;
   logic [VAR_W-1:0]   var_ff;
   logic               gt_ff;
   logic [LHS_W-1:0]   lhs_ff;
   logic [RHS_W-1:0]   rhs_ff;
   logic [DD_W-1:0]    dd;

   logic               hit, det;
   logic [HITS_W:0]    miss_next;
   logic               miss_over;
   logic [HITS_W-1:0]  hit_count_ff, hit_count_in, miss_count_ff, miss_count_in;
   logic               refr_ff, refr_in;
   logic               rsp_valid_ff;
   result_type         rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_MUL:  state_in = BK_DIFF;
         BK_DIFF: state_in = BK_SQ;
         BK_SQ:   state_in = BK_DONE;
         BK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign dd = DD_W'(d_ff) * DD_W'(d_ff);

   always_ff @(posedge clock) begin
      if (pop) begin
         n_ff  <= pop_n;
         s1_ff <= pop_sum;
         s2_ff <= pop_sq;
         m_ff  <= pop_max;
         k_ff  <= K_W'(cfg.z_q4) * K_W'(cfg.z_q4);
      end
      if (state_ff == BK_MUL) begin
         nm_ff <= NM_W'(n_ff) * NM_W'(m_ff);
         a_ff  <= A_W'(n_ff) * A_W'(s2_ff);
         b_ff  <= B_W'(s1_ff) * B_W'(s1_ff);
      end
      if (state_ff == BK_DIFF) begin
         gt_ff  <= (nm_ff > NM_W'(s1_ff));
         d_ff   <= nm_ff - NM_W'(s1_ff);
         var_ff <= (VAR_W'(a_ff) >= VAR_W'(b_ff)) ? (VAR_W'(a_ff) - VAR_W'(b_ff)) : '0;
      end
      if (state_ff == BK_SQ) begin
         lhs_ff <= {dd, 8'h00};
         rhs_ff <= RHS_W'(var_ff) * RHS_W'(k_ff);
      end
   end

   assign hit       = gt_ff && (CMP_W'(rhs_ff) < CMP_W'(lhs_ff));
   assign miss_next = {1'b0, miss_count_ff} + (HITS_W + 1)'(1);
   assign miss_over = (miss_next > {1'b0, cfg.miss_limit});

   always_comb begin
      hit_count_in  = hit_count_ff;
      miss_count_in = miss_count_ff;
      refr_in       = refr_ff;
      det           = 1'b0;
      if (refr_ff) begin
         if (!hit) begin
            if (miss_over) begin
               hit_count_in  = '0;
               miss_count_in = '0;
               refr_in       = 1'b0;
            end else begin
               miss_count_in = miss_next[HITS_W-1:0];
            end
         end
      end else begin
         if (hit) begin
            if (hit_count_ff != HITS_MAX) begin
               hit_count_in = hit_count_ff + HITS_W'(1);
            end
            miss_count_in = '0;
         end else if (hit_count_ff != '0) begin
            if (miss_over) begin
               hit_count_in  = '0;
               miss_count_in = '0;
            end else begin
               miss_count_in = miss_next[HITS_W-1:0];
            end
         end
         if (hit_count_in >= cfg.hit_frames) begin
            det           = 1'b1;
            hit_count_in  = '0;
            miss_count_in = '0;
            refr_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
         refr_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (out_load) begin
         hit_count_ff  <= hit_count_in;
         miss_count_ff <= miss_count_in;
         refr_ff       <= refr_in;
         rsp_valid_ff  <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.band_hit    <= hit;
         rsp_ff.detected    <= det;
         rsp_ff.hits_so_far <= hit_count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: hdl/spectral_tone_burst_detector.sv
// Top level of the spectral tone burst detector: registers, front, queue and back.
`timescale 1ns / 1ps
// The block takes one spectrum magnitude bin per word on the req_ channel; a word
// with req_frame_end set closes a frame. For each closed frame exactly one word
// leaves on the rsp_ channel with the z-score result and the detection flag.
// Bins are taken at one per cycle while req_stall is low. A sequencer evaluates
// each frame in the states BK_IDLE, BK_MUL, BK_DIFF, BK_SQ and BK_DONE, and a
// four-entry queue of frame statistics lies between the accumulator and that
// sequencer. Back-to-back short frames fill the queue and then raise req_stall until
// an entry is freed. With the back part idle and the output free, frame statistics
// go from the pipeline register through the queue and those states to the output.
// The output word is held in a register; while rsp_stall is high it stays put
// and the evaluation of the next frame waits, and bins go on filling the queue.
// The configuration is written through csr_write, csr_index and csr_data; the user must
// do so only while no frame is open or being evaluated; the block does not enforce it.
// A synchronous reset clears all accumulators, the hit and miss counters and
// the refractory flag, empties the queue and restores the default settings.
module spectral_tone_burst_detector #(
   parameter int MAX_BINS = 1024,
   parameter int MAG_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_magnitude,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_band_hit,
   output logic                                rsp_detected,
   output logic [7:0]                          rsp_hits_so_far,
   input  logic                                csr_write,
   input  logic [stbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stbd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import stbd_pkg::*;

   localparam int MAG_W = (MAG_BITS < MAG_PORT_W) ? MAG_BITS : MAG_PORT_W;
   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam int S1_W  = CNT_W + MAG_W;
   localparam int S2_W  = CNT_W + 2 * MAG_W;
   localparam int Q_W   = CNT_W + S1_W + S2_W + MAG_W;

   cfg_type                cfg_ff;
   logic                   push, pop, queue_empty;
   logic [QUEUE_LVL_W-1:0] queue_level;
   logic [CNT_W-1:0]       push_n, pop_n;
   logic [S1_W-1:0]        push_sum, pop_sum;
   logic [S2_W-1:0]        push_sq, pop_sq;
   logic [MAG_W-1:0]       push_max, pop_max;
   logic [Q_W-1:0]         pop_data;
   result_type             rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_first_bin <= RESET_BAND_FIRST;
         cfg_ff.band_last_bin  <= RESET_BAND_LAST;
         cfg_ff.z_q4           <= RESET_Z_Q4;
         cfg_ff.hit_frames     <= RESET_HIT_FRAMES;
         cfg_ff.miss_limit     <= RESET_MISS_LIMIT;
      end else if (csr_write) begin
         case (csr_index)
            REG_BAND_FIRST: cfg_ff.band_first_bin <= csr_data[BIN_W-1:0];
            REG_BAND_LAST:  cfg_ff.band_last_bin  <= csr_data[BIN_W-1:0];
            REG_Z_Q4:       cfg_ff.z_q4           <= csr_data[THR_W-1:0];
            REG_HIT_FRAMES: cfg_ff.hit_frames     <= csr_data[HITS_W-1:0];
            REG_MISS_LIMIT: cfg_ff.miss_limit     <= csr_data[HITS_W-1:0];
            default: ;
         endcase
      end
   end

   stbd_front #(
      .MAX_BINS (MAX_BINS),
      .CNT_W    (CNT_W),
      .MAG_W    (MAG_W),
      .S1_W     (S1_W),
      .S2_W     (S2_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_magnitude (req_magnitude[MAG_W-1:0]),
      .req_frame_end (req_frame_end),
      .queue_level   (queue_level),
      .push          (push),
      .push_n        (push_n),
      .push_sum      (push_sum),
      .push_sq       (push_sq),
      .push_max      (push_max)
   );

   stbd_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_n, push_sum, push_sq, push_max}),
      .pop       (pop),
      .pop_data  (pop_data),
      .level     (queue_level),
      .empty     (queue_empty)
   );

   assign {pop_n, pop_sum, pop_sq, pop_max} = pop_data;

   stbd_back #(
      .CNT_W (CNT_W),
      .MAG_W (MAG_W),
      .S1_W  (S1_W),
      .S2_W  (S2_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop         (pop),
      .pop_n       (pop_n),
      .pop_sum     (pop_sum),
      .pop_sq      (pop_sq),
      .pop_max     (pop_max),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   assign rsp_band_hit    = rsp.band_hit;
   assign rsp_detected    = rsp.detected;
   assign rsp_hits_so_far = rsp.hits_so_far;

endmodule

// File: hdl/stbd_checker.sv
// Port-level checks of the spectral tone burst detector, bound to its top level.
`timescale 1ns / 1ps
`include "spectral_tone_burst_detector_macros.svh"
module stbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_band_hit,
   input logic       rsp_detected,
   input logic [7:0] rsp_hits_so_far
);

   `STBD_ASSERT_ALWAYS(a_no_word_after_reset, reset |=> !rsp_valid, "result word shown after reset")
   `STBD_ASSERT_ALWAYS(a_ready_after_reset, reset |=> !req_stall, "input stalled after reset")
   `STBD_ASSERT(a_detect_clears_hits, rsp_valid && rsp_detected |-> rsp_hits_so_far == 8'd0, "detection word carries a non-zero hit count")
   `STBD_ASSERT(a_rsp_held, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_band_hit) && $stable(rsp_detected) && $stable(rsp_hits_so_far), "stalled result word changed")

endmodule

bind spectral_tone_burst_detector stbd_checker u_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the spectral tone burst detector, driven by a table and by random frames.
`timescale 1ns / 1ps
module testbench;
   import stbd_pkg::*;

   localparam int MAX_BINS       = 1024;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 16;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SEGMENTS       = 8;
   localparam int SEGMENT_WORDS  = 145;
   localparam int OVERLONG_LEN   = MAX_BINS + 6;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 3'd7;

   typedef enum logic {ROW_BIN, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [15:0]            value;
      logic                   last;
      logic                   typed;
      result_type             want;
   } script_row_type;

   localparam int SCRIPT_LEN = 29;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{ROW_BIN, '0,             16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
      '{ROW_BIN, '0,             16'h0000, 1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'h0000, 1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
      '{ROW_CSR, REG_BAND_FIRST, 16'd0,    1'b0, 1'b0, '0},
      '{ROW_CSR, REG_BAND_LAST,  16'd1023, 1'b0, 1'b0, '0},
      '{ROW_CSR, REG_Z_Q4,       16'd0,    1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'h0000, 1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'hFFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd1}},
      '{ROW_BIN, '0,             16'd5,    1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'd5,    1'b1, 1'b1, '{1'b0, 1'b0, 8'd1}},
      '{ROW_CSR, REG_HIT_FRAMES, 16'd0,    1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'd7,    1'b1, 1'b1, '{1'b0, 1'b1, 8'd0}},
      '{ROW_BIN, '0,             16'h0000, 1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'hFFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 8'd0}},
      '{ROW_CSR, REG_MISS_LIMIT, 16'd0,    1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'd9,    1'b1, 1'b1, '{1'b0, 1'b0, 8'd0}},
      '{ROW_BIN, '0,             16'd1,    1'b1, 1'b1, '{1'b0, 1'b1, 8'd0}},
      '{ROW_CSR, REG_SPARE,      16'd1023, 1'b0, 1'b0, '0},
      '{ROW_CSR, REG_Z_Q4,       16'd255,  1'b0, 1'b0, '0},
      '{ROW_CSR, REG_HIT_FRAMES, 16'd255,  1'b0, 1'b0, '0},
      '{ROW_CSR, REG_MISS_LIMIT, 16'd255,  1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'h0000, 1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'h0000, 1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'h0000, 1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'hFFFF, 1'b1, 1'b0, '0},
      '{ROW_CSR, REG_BAND_FIRST, 16'd1023, 1'b0, 1'b0, '0},
      '{ROW_CSR, REG_BAND_LAST,  16'd0,    1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'hFFFF, 1'b0, 1'b0, '0},
      '{ROW_BIN, '0,             16'h0000, 1'b1, 1'b0, '0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [15:0]            req_magnitude;
   logic                   req_frame_end;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_band_hit;
   logic                   rsp_detected;
   logic [7:0]             rsp_hits_so_far;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Predicted state of the block: frame accumulators, counters and settings.
   cfg_type      cfg;
   logic [10:0]  acc_bins;
   logic [25:0]  acc_sum;
   logic [41:0]  acc_sumsq;
   logic [15:0]  acc_peak;
   logic [7:0]   hit_run;
   logic [7:0]   miss_run;
   logic         holdoff;

   result_type   awaited[$];
   int           error_count;
   int           words_sent;
   int           send_idle_pct;
   int           stall_pct;
   bit           hold_request;

   spectral_tone_burst_detector u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_magnitude   (req_magnitude),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_band_hit    (rsp_band_hit),
      .rsp_detected    (rsp_detected),
      .rsp_hits_so_far (rsp_hits_so_far),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Exact integer form of: some band bin lies above mean + z * standard deviation.
   function automatic bit tone_exceeds_threshold();
      logic [127:0] nm, d, lhs, spread, rhs, z_sq;
      nm = 128'(acc_bins) * 128'(acc_peak);
      if (nm <= 128'(acc_sum)) return 1'b0;
      d = nm - 128'(acc_sum);
      lhs = (d * d) << 8;
      spread = 128'(acc_bins) * 128'(acc_sumsq);
      rhs = 128'(acc_sum) * 128'(acc_sum);
      spread = (spread >= rhs) ? spread - rhs : '0;
      z_sq = 128'(cfg.z_q4) * 128'(cfg.z_q4);
      rhs = spread * z_sq;
      return rhs < lhs;
   endfunction

   function automatic void take_bin(input logic [15:0] mag, input logic last,
                                    output logic closes, output result_type r);
      logic hit, det;
      closes = 1'b0;
      r = '0;
      if (acc_bins < MAX_BINS) begin
         if (acc_bins >= cfg.band_first_bin && acc_bins <= cfg.band_last_bin &&
             mag > acc_peak) begin
            acc_peak = mag;
         end
         acc_sum += mag;
         acc_sumsq += mag * mag;
         acc_bins++;
      end
      if (!last) return;
      hit = tone_exceeds_threshold();
      det = 1'b0;
      if (holdoff) begin
         if (!hit) begin
            if ({1'b0, miss_run} + 9'd1 > {1'b0, cfg.miss_limit}) begin
               hit_run = '0;
               miss_run = '0;
               holdoff = 1'b0;
            end else begin
               miss_run++;
            end
         end
      end else begin
         if (hit) begin
            if (hit_run != HITS_MAX) hit_run++;
            miss_run = '0;
         end else if (hit_run != '0) begin
            if ({1'b0, miss_run} + 9'd1 > {1'b0, cfg.miss_limit}) begin
               hit_run = '0;
               miss_run = '0;
            end else begin
               miss_run++;
            end
         end
         if (hit_run >= cfg.hit_frames) begin
            det = 1'b1;
            hit_run = '0;
            miss_run = '0;
            holdoff = 1'b1;
         end
      end
      closes = 1'b1;
      r = '{hit, det, hit_run};
      acc_bins = '0;
      acc_sum = '0;
      acc_sumsq = '0;
      acc_peak = '0;
   endfunction

   task automatic send_word(input logic [15:0] mag, input logic last, input logic typed,
                            input result_type want);
      result_type r;
      logic closes;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_magnitude <= mag;
      req_frame_end <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      take_bin(mag, last, closes, r);
      if (closes) awaited.push_back(typed ? want : r);
   endtask

   // A tone frame carries one strong bin inside the band, where the band reaches the frame.
   task automatic send_frame(input int len, input bit tone);
      int noise_bits, lo, hi, peak_at;
      logic [15:0] mag;
      noise_bits = $urandom_range(16, 0);
      lo = cfg.band_first_bin;
      hi = cfg.band_last_bin;
      if (hi > len - 1) hi = len - 1;
      peak_at = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(len - 1, 0);
      for (int i = 0; i < len; i++) begin
         mag = 16'($urandom & ((32'd1 << noise_bits) - 32'd1));
         if (tone && i == peak_at) begin
            mag = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(16'hFFFF, 16'h2000));
         end
         send_word(mag, i == len - 1, 1'b0, '0);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         REG_BAND_FIRST: cfg.band_first_bin = data[BIN_W-1:0];
         REG_BAND_LAST:  cfg.band_last_bin = data[BIN_W-1:0];
         REG_Z_Q4:       cfg.z_q4 = data[THR_W-1:0];
         REG_HIT_FRAMES: cfg.hit_frames = data[HITS_W-1:0];
         REG_MISS_LIMIT: cfg.miss_limit = data[HITS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(REG_BAND_FIRST, CSR_DATA_W'(c.band_first_bin));
      write_reg(REG_BAND_LAST, CSR_DATA_W'(c.band_last_bin));
      write_reg(REG_Z_Q4, CSR_DATA_W'(c.z_q4));
      write_reg(REG_HIT_FRAMES, CSR_DATA_W'(c.hit_frames));
      write_reg(REG_MISS_LIMIT, CSR_DATA_W'(c.miss_limit));
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited.size() == 0) begin
            flag_error("result word arrived with none awaited");
         end else begin
            want = awaited.pop_front();
            if (rsp_band_hit !== want.band_hit)
               flag_error($sformatf("band_hit %0b, awaited %0b", rsp_band_hit, want.band_hit));
            if (rsp_detected !== want.detected)
               flag_error($sformatf("detected %0b, awaited %0b", rsp_detected, want.detected));
            if (rsp_hits_so_far !== want.hits_so_far)
               flag_error($sformatf("hits_so_far %0d, awaited %0d", rsp_hits_so_far,
                                    want.hits_so_far));
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      cfg_type pick;
      int target, len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_magnitude = '0;
      req_frame_end = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg = '{RESET_BAND_FIRST, RESET_BAND_LAST, RESET_Z_Q4, RESET_HIT_FRAMES,
              RESET_MISS_LIMIT};
      acc_bins = '0;
      acc_sum = '0;
      acc_sumsq = '0;
      acc_peak = '0;
      hit_run = '0;
      miss_run = '0;
      holdoff = 1'b0;
      error_count = 0;
      words_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_LEN; r++) begin
         if (SCRIPT[r].kind == ROW_CSR) begin
            drain_results();
            write_reg(SCRIPT[r].index, SCRIPT[r].value[CSR_DATA_W-1:0]);
         end else begin
            send_word(SCRIPT[r].value, SCRIPT[r].last, SCRIPT[r].typed, SCRIPT[r].want);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         pick.band_first_bin = 10'($urandom_range(8, 0));
         pick.band_last_bin = ($urandom_range(9) == 0) ? 10'($urandom_range(1023, 0)) :
                              pick.band_first_bin + 10'($urandom_range(12, 0));
         pick.z_q4 = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 0)) :
                     8'($urandom_range(56, 8));
         pick.hit_frames = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 0)) :
                           8'($urandom_range(6, 1));
         pick.miss_limit = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 0)) :
                           8'($urandom_range(5, 0));
         apply_settings(pick);
         target = words_sent + SEGMENT_WORDS;
         while (words_sent < target) begin
            len = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(120, 25);
            send_frame(len, $urandom_range(99) < 65);
         end
      end

      // The receiver holds off while short frames keep coming, so the frame queue fills.
      drain_results();
      send_idle_pct = 0;
      stall_pct = 37;
      hold_request = 1'b1;
      repeat (40) send_frame($urandom_range(2, 1), $urandom_range(1));
      drain_results();

      // Long runs of single-bin frames, which can never pass the test, probe the widest miss limit.
      pick = '{10'd0, 10'd1023, 8'd0, 8'd2, 8'd255};
      apply_settings(pick);
      send_frame(2, 1'b1);
      repeat (256) send_frame(1, 1'b0);
      send_frame(2, 1'b1);
      send_frame(2, 1'b1);
      repeat (256) send_frame(1, 1'b0);
      send_frame(2, 1'b1);
      drain_results();

      pick = '{10'd1023, 10'd1023, 8'd16, 8'd1, 8'd0};
      apply_settings(pick);
      send_idle_pct = 37;
      for (int i = 0; i < OVERLONG_LEN; i++) begin
         send_word((i == MAX_BINS - 1) ? 16'hFFFF :
                   (i >= MAX_BINS) ? 16'($urandom) : 16'($urandom_range(15, 0)),
                   i == OVERLONG_LEN - 1, 1'b0, '0);
      end
      drain_results();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
